[rtl/cmft_pkg.sv]
package cmft_pkg;

  localparam int LABEL_W = 6;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CLASSES = 2'd2;

  localparam logic [6:0] BLOCK_SIZE_RST = 7'd8;
  localparam logic [12:0] IMAGE_WIDTH_RST = 13'd512;
  localparam logic [6:0] NUM_CLASSES_RST = 7'd32;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MV0  = 4'b0010,
    ST_MV1  = 4'b0100,
    ST_MV2  = 4'b1000
  } state_t;

  typedef struct packed {
    logic en;
    logic [LABEL_W-1:0] label;
  } move_cmd_t;

endpackage

[rtl/cmft_cell.sv]
module cmft_cell #(
  parameter int IDX = 0,
  parameter int RW = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmft_pkg::move_cmd_t  cmd,
  input  logic [RW-1:0]        old_rank,
  input  logic [6:0]           num_classes,
  input  logic [5:0]           query,
  output logic [RW-1:0]        lab_rank,
  output logic [RW-1:0]        q_rank,
  output logic                 q_hit,
  output logic                 q_act
);
  import cmft_pkg::*;

  localparam logic [8:0] IDX9 = 9'(IDX);

  logic [RW-1:0] rank;
  logic          lab_match;
  logic          active;

  assign lab_match = ({3'b0, cmd.label} == IDX9);
  assign active = (IDX9 < {2'b0, num_classes});
  assign q_hit = ({3'b0, query} == IDX9);
  assign q_act = active;
  assign lab_rank = lab_match ? rank : '0;
  assign q_rank = q_hit ? rank : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RW'(IDX);
    end else if (cmd.en) begin
      if (lab_match) begin
        rank <= '0;
      end else if (active && (rank < old_rank)) begin
        rank <= rank + RW'(1);
      end
    end
  end

endmodule

[rtl/context_move_to_front_ranks_top.sv]
// Context move-to-front rank table.
// Command channel: an item (row, col, label_up, label_left, label_up_right,
// query_label) is taken at a rising edge where start is high and busy is low.
// Three reference labels are chosen from the neighbors and each is moved to
// rank zero in turn, one move per cycle, across a row of cells that each hold
// the rank of one label and compare and increment it in parallel.
// The rank of query_label after the third move is registered on query_rank at
// the end of that move, together with done, which is high for exactly one cycle.
// A new item can be taken during the third move, so when start is held high
// the moves of the next item follow on directly.
// The receiver cannot stall: each result must be taken in its done cycle.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always accepted
// and should only be issued while the block is idle. Index 0 is block_size,
// 1 is image_width and 2 is num_classes; other indexes are ignored.
// Synchronous reset restores the identity rank table and the register
// defaults (block_size 8, image_width 512, num_classes 32).
module context_move_to_front_ranks_top #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [11:0]                        row,
  input  logic [11:0]                        col,
  input  logic [5:0]                         label_up,
  input  logic [5:0]                         label_left,
  input  logic [5:0]                         label_up_right,
  input  logic [5:0]                         query_label,
  output logic                               done,
  output logic [5:0]                         query_rank,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cmft_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cmft_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cmft_pkg::*;

  localparam int RW = $clog2(MAX_CLASSES);

  state_t state, state_next;
  logic [6:0]  block_size;
  logic [12:0] image_width;
  logic [6:0]  num_classes;
  logic [5:0]  refs [3];
  logic [5:0]  query;
  logic        accept;
  logic [5:0]  r0, r1, r2;
  logic [5:0]  n0, n1, n2;
  logic        edge_fall;

  move_cmd_t     cmd;
  logic [RW-1:0] lab_rank [MAX_CLASSES];
  logic [RW-1:0] q_rank [MAX_CLASSES];
  logic          q_hit [MAX_CLASSES];
  logic          q_act [MAX_CLASSES];
  logic [RW-1:0] old_rank;
  logic          lab_found;
  logic [RW-1:0] q_old;
  logic          q_found;
  logic          q_in_use;
  logic [RW-1:0] q_new;
  logic [RW+5:0] q_ext;

  assign cfg_ready = 1'b1;
  assign busy = (state == ST_MV0) || (state == ST_MV1);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RST;
      image_width <= IMAGE_WIDTH_RST;
      num_classes <= NUM_CLASSES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:  block_size <= cfg_data[6:0];
        CFG_IMAGE_WIDTH: image_width <= cfg_data;
        CFG_NUM_CLASSES: num_classes <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign edge_fall = ({1'b0, col} + {6'b0, block_size}) >= image_width;

  always_comb begin
    if (row == 12'd0) begin
      r0 = (col == 12'd0) ? 6'd0 : label_left;
      r1 = r0;
      r2 = r0;
    end else begin
      r0 = label_up;
      r1 = (col == 12'd0) ? label_up : label_left;
      r2 = edge_fall ? label_up : label_up_right;
    end
    n0 = r0;
    n1 = r1;
    n2 = r2;
    if ((row != 12'd0) && (r1 == r2)) begin
      n2 = r0;
      n0 = r1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_MV0;
      ST_MV0:  state_next = ST_MV1;
      ST_MV1:  state_next = ST_MV2;
      ST_MV2:  state_next = accept ? ST_MV0 : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      refs[0] <= n2;
      refs[1] <= n1;
      refs[2] <= n0;
      query <= query_label;
    end else if ((state == ST_MV0) || (state == ST_MV1)) begin
      refs[0] <= refs[1];
      refs[1] <= refs[2];
    end
  end

  always_comb begin
    old_rank = '0;
    lab_found = 1'b0;
    q_old = '0;
    q_found = 1'b0;
    q_in_use = 1'b0;
    for (int i = 0; i < MAX_CLASSES; i++) begin
      old_rank = old_rank | lab_rank[i];
      lab_found = lab_found | ({3'b0, refs[0]} == 9'(i));
      q_old = q_old | q_rank[i];
      q_found = q_found | q_hit[i];
      q_in_use = q_in_use | (q_hit[i] & q_act[i]);
    end
  end

  assign cmd.label = refs[0];
  assign cmd.en = (state != ST_IDLE) && lab_found && (old_rank != '0);

  genvar g;
  generate
    for (g = 0; g < MAX_CLASSES; g++) begin : g_cell
      cmft_cell #(
        .IDX (g),
        .RW  (RW)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .old_rank    (old_rank),
        .num_classes (num_classes),
        .query       (query),
        .lab_rank    (lab_rank[g]),
        .q_rank      (q_rank[g]),
        .q_hit       (q_hit[g]),
        .q_act       (q_act[g])
      );
    end
  endgenerate

  // The reported rank accounts for the last move, which lands in the table at
  // the same edge.
  always_comb begin
    q_new = q_old;
    if (!q_found) begin
      q_new = '0;
    end else if (cmd.en) begin
      if (query == refs[0]) begin
        q_new = '0;
      end else if (q_in_use && (q_old < old_rank)) begin
        q_new = q_old + RW'(1);
      end
    end
  end

  assign q_ext = {6'b0, q_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_MV2);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MV2) begin
      query_rank <= q_ext[5:0];
    end
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cmft_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [11:0] row;
    logic [11:0] col;
    logic [5:0]  up;
    logic [5:0]  left;
    logic [5:0]  up_right;
    logic [5:0]  query;
  } block_item_t;

  class rank_tracker;
    int ranks[TABLE_DEPTH];
    int blk_step;
    int img_width;
    int class_count;
    logic [5:0] expected_ranks[$];
    int mismatches;
    int checked;
    int first_row_items;
    int edge_fallbacks;
    int swapped_refs;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) ranks[i] = i;
      blk_step = BLOCK_SIZE_RST;
      img_width = IMAGE_WIDTH_RST;
      class_count = NUM_CLASSES_RST;
      mismatches = 0;
      checked = 0;
      first_row_items = 0;
      edge_fallbacks = 0;
      swapped_refs = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BLOCK_SIZE: blk_step = data[6:0];
        CFG_IMAGE_WIDTH: img_width = data[12:0];
        CFG_NUM_CLASSES: class_count = data[6:0];
        default: ;
      endcase
    endfunction

    function void move_front(logic [5:0] lbl);
      int old_rank;
      int lim;
      old_rank = ranks[lbl];
      if (old_rank == 0) return;
      lim = (class_count > TABLE_DEPTH) ? TABLE_DEPTH : class_count;
      for (int i = 0; i < lim; i++) begin
        if (ranks[i] < old_rank) ranks[i] = ranks[i] + 1;
      end
      ranks[lbl] = 0;
    endfunction

    function void note_item(block_item_t it);
      logic [5:0] ref_up, ref_left, ref_up_right;
      if (it.row == 0) begin
        first_row_items++;
        ref_up = (it.col == 0) ? 6'd0 : it.left;
        ref_left = ref_up;
        ref_up_right = ref_up;
      end else begin
        ref_up = it.up;
        ref_left = (it.col == 0) ? it.up : it.left;
        if (int'(it.col) + blk_step >= img_width) begin
          ref_up_right = it.up;
          edge_fallbacks++;
        end else begin
          ref_up_right = it.up_right;
        end
        if (ref_left == ref_up_right) begin
          ref_up_right = ref_up;
          ref_up = ref_left;
          swapped_refs++;
        end
      end
      move_front(ref_up_right);
      move_front(ref_left);
      move_front(ref_up);
      expected_ranks.push_back(6'(ranks[it.query]));
    endfunction

    function void check_rank(logic [5:0] actual);
      logic [5:0] exp_rank;
      if (expected_ranks.size() == 0) begin
        $error("query_rank: unexpected result, expected none, actual %0d", actual);
        mismatches++;
        return;
      end
      exp_rank = expected_ranks.pop_front();
      checked++;
      if (actual !== exp_rank) begin
        $error("query_rank mismatch: expected %0d, actual %0d", exp_rank, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_ranks.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [11:0] row;
  logic [11:0] col;
  logic [5:0] label_up;
  logic [5:0] label_left;
  logic [5:0] label_up_right;
  logic [5:0] query_label;
  logic done;
  logic [5:0] query_rank;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rank_tracker tracker = new();
  int items_sent = 0;
  int reg_writes = 0;

  context_move_to_front_ranks_top u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .row(row),
    .col(col),
    .label_up(label_up),
    .label_left(label_left),
    .label_up_right(label_up_right),
    .query_label(query_label),
    .done(done),
    .query_rank(query_rank),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_rank(query_rank);
  end

  function automatic block_item_t mk(int r, int c, int u, int l, int ur, int q);
    block_item_t it;
    it.row = 12'(r);
    it.col = 12'(c);
    it.up = 6'(u);
    it.left = 6'(l);
    it.up_right = 6'(ur);
    it.query = 6'(q);
    return it;
  endfunction

  function automatic block_item_t random_item();
    block_item_t it;
    int lbl_span;
    int pick;
    int c;
    lbl_span = (tracker.class_count == 0) ? 1 :
               (tracker.class_count > TABLE_DEPTH) ? TABLE_DEPTH : tracker.class_count;
    pick = $urandom_range(99);
    if (pick < 15) it.row = 12'd0;
    else if (pick < 85) it.row = 12'($urandom_range(1, 40));
    else it.row = 12'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      it.col = 12'd0;
    end else if (pick < 45) begin
      c = tracker.img_width - tracker.blk_step - 1 + $urandom_range(1);
      if (c < 0) c = 0;
      if (c > 4095) c = 4095;
      it.col = 12'(c);
    end else if (pick < 80 && tracker.img_width > 0) begin
      c = (tracker.img_width > 4096) ? 4095 : tracker.img_width - 1;
      it.col = 12'($urandom_range(0, c));
    end else begin
      it.col = 12'($urandom);
    end
    if ($urandom_range(99) < 80) begin
      it.up = 6'($urandom_range(0, lbl_span - 1));
      it.left = 6'($urandom_range(0, lbl_span - 1));
      it.up_right = 6'($urandom_range(0, lbl_span - 1));
    end else begin
      it.up = 6'($urandom);
      it.left = 6'($urandom);
      it.up_right = 6'($urandom);
    end
    if ($urandom_range(3) == 0) it.up_right = it.left;
    pick = $urandom_range(9);
    if (pick < 2) it.query = it.up;
    else if (pick < 4) it.query = it.left;
    else if (pick < 5) it.query = it.up_right;
    else if (pick < 8) it.query = 6'($urandom_range(0, lbl_span - 1));
    else it.query = 6'($urandom);
    return it;
  endfunction

  task automatic send_item(input block_item_t it);
    row = it.row;
    col = it.col;
    label_up = it.up;
    label_left = it.left;
    label_up_right = it.up_right;
    query_label = it.query;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(input int bs_data, input int iw_data, input int nc_data,
                           input int count, input bit idle_on);
    bit quiet;
    quiet = 1'b0;
    drain();
    write_reg(CFG_BLOCK_SIZE, 13'(bs_data));
    write_reg(CFG_IMAGE_WIDTH, 13'(iw_data));
    write_reg(CFG_NUM_CLASSES, 13'(nc_data));
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) quiet = ($urandom_range(3) == 0);
      if (idle_on && !quiet && $urandom_range(4) == 0) pause_sender($urandom_range(1, 19));
      send_item(random_item());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    row = '0;
    col = '0;
    label_up = '0;
    label_left = '0;
    label_up_right = '0;
    query_label = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(mk(0, 0, 63, 63, 63, 0));
    send_item(mk(0, 1, 0, 31, 0, 31));
    send_item(mk(0, 4095, 63, 63, 63, 63));
    pause_sender(2);
    send_item(mk(0, 7, 5, 0, 9, 0));
    send_item(mk(1, 0, 10, 45, 20, 10));
    send_item(mk(4095, 4095, 63, 0, 1, 1));
    send_item(mk(2, 503, 3, 4, 5, 5));
    pause_sender(1);
    send_item(mk(2, 504, 6, 7, 8, 8));
    send_item(mk(3, 100, 12, 33, 33, 12));
    send_item(mk(3, 0, 17, 2, 17, 17));
    send_item(mk(5, 200, 40, 40, 40, 40));
    send_item(mk(5, 200, 0, 0, 0, 0));
    send_item(mk(7, 9, 31, 30, 29, 29));
    send_item(mk(4095, 0, 0, 63, 63, 63));
    send_item(mk(1, 4095, 1, 2, 3, 0));
    send_item(mk(6, 300, 63, 62, 61, 61));
    send_item(mk(2048, 2048, 42, 21, 42, 42));
    send_item(mk(0, 2, 21, 42, 21, 42));
    send_item(mk(9, 10, 11, 12, 11, 11));
    send_item(mk(10, 20, 30, 20, 20, 20));
    drain();
    write_reg(CFG_UNUSED, 13'h1FFF);

    run_phase(64, 4096, 64, 200, 1'b1);
    run_phase(13'h1FFF, 0, 0, 150, 1'b1);
    run_phase(1, 1, 127, 200, 1'b1);
    run_phase(0, 13'h1FFF, 1, 150, 1'b1);
    run_phase($urandom_range(1, 64), $urandom_range(1, 4096), $urandom_range(2, 64), 200, 1'b1);
    run_phase($urandom_range(1, 64), $urandom_range(1, 4096), $urandom_range(2, 64), 200, 1'b1);
    run_phase(8, 64, 64, 250, 1'b0);
    run_phase($urandom_range(1, 64), $urandom_range(1, 256), $urandom_range(65, 127), 250, 1'b0);
    drain();

    if (tracker.pending() != 0) begin
      $error("query_rank: %0d expected results never arrived", tracker.pending());
      tracker.mismatches++;
    end
    $display("summary: %0d items sent, %0d ranks checked, %0d register writes",
             items_sent, tracker.checked, reg_writes);
    $display("summary: %0d first-row items, %0d right-edge fallbacks, %0d swapped references",
             tracker.first_row_items, tracker.edge_fallbacks, tracker.swapped_refs);
    if (tracker.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
